// ----- src/rhsv_pkg.sv -----
// Shared types and constants for the RGB to HSV converter.
// No dependencies; used by the converter and the checker.
package rhsv_pkg;

    // Pixel request and result payloads
    typedef struct packed {
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [8:0] hue_deg;
        logic [6:0] sat_pct;
        logic [6:0] val_pct;
    } hsv_t;

    // Dominant channel, red wins ties over green, green over blue
    typedef enum logic [1:0] {
        SEC_RED   = 2'd0,
        SEC_GREEN = 2'd1,
        SEC_BLUE  = 2'd2
    } sector_t;

    // Divider geometry: quotient bits (one per stage) and operand widths
    localparam int QW     = 9;
    localparam int HUE_NW = 18;
    localparam int PCT_NW = 16;
    localparam int DEN_W  = 9;

    // Scale factors
    localparam logic [17:0] HUE_K60  = 18'd60;
    localparam logic [17:0] HUE_K120 = 18'd120;
    localparam logic [17:0] HUE_K240 = 18'd240;
    localparam logic [17:0] HUE_K360 = 18'd360;
    localparam logic [15:0] PCT_K200 = 16'd200;  // twice 100, for half-up rounding

    // Value: floor((100*mx + 127) / 255) by reciprocal multiply, exact below 2**15
    localparam logic [14:0] VAL_K100  = 15'd100;
    localparam logic [14:0] VAL_HALF  = 15'd127;
    localparam logic [29:0] VAL_RECIP = 30'd32897;  // ceil(2**23 / 255)
    localparam int          VAL_SHIFT = 23;

endpackage

// ----- src/rgb_to_hsv_converter.sv -----
// Channel  | Dir | Handshake              | Payload
// pixel    | in  | pixel_valid/pixel_stall | rhsv_pkg::pixel_t (red, green, blue)
// hsv      | out | hsv_valid/hsv_stall     | rhsv_pkg::hsv_t (hue, sat, value)
//
// One request per clock while the output is not stalled; each result passes
// through two stages of range and numerator set-up, then nine stages of the
// bit-per-stage dividers (hue and saturation run side by side; the value is
// formed by a constant reciprocal multiply in the second set-up stage and
// rides alongside the dividers).
// Reset clears every stage valid bit; no results until fresh requests enter.
// A stall from the output holds only the full tail of the pipeline; empty
// stages ahead of it keep filling, so a bubble is squeezed out rather than
// kept.
// Depends on rhsv_pkg and rhsv_div.
module rgb_to_hsv_converter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pixel_valid,
    output logic             pixel_stall,
    input  rhsv_pkg::pixel_t pixel,
    output logic             hsv_valid,
    input  logic             hsv_stall,
    output rhsv_pkg::hsv_t   hsv
);

    localparam int QW = rhsv_pkg::QW;
    localparam int NS = QW + 2;   // set-up stages plus divider stages

    // Stage valid bits and per-stage advance: a stage loads when it is empty
    // or the stage after it moves on.
    logic [NS-1:0] v_reg;
    logic [NS:0]   adv;

    assign adv[NS] = !hsv_stall;
    for (genvar i = 0; i < NS; i++) begin : g_adv
        assign adv[i] = !v_reg[i] || adv[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= pixel_valid;
            end
            for (int i = 1; i < NS; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    assign pixel_stall = !adv[0];
    assign hsv_valid   = v_reg[NS-1];

    // Stage A: largest, smallest, range and dominant channel
    logic [7:0] r_reg, g_reg, b_reg, mx_reg, rng_reg;
    rhsv_pkg::sector_t sec_reg;

    logic [7:0] mx_next, mn_next;
    rhsv_pkg::sector_t sec_next;

    always_comb
    begin
        mx_next = pixel.red_in;
        mn_next = pixel.red_in;
        if (pixel.green_in > mx_next) mx_next = pixel.green_in;
        if (pixel.blue_in  > mx_next) mx_next = pixel.blue_in;
        if (pixel.green_in < mn_next) mn_next = pixel.green_in;
        if (pixel.blue_in  < mn_next) mn_next = pixel.blue_in;

        priority if (mx_next == pixel.red_in)
            sec_next = rhsv_pkg::SEC_RED;
        else if (mx_next == pixel.green_in)
            sec_next = rhsv_pkg::SEC_GREEN;
        else
            sec_next = rhsv_pkg::SEC_BLUE;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            r_reg   <= pixel.red_in;
            g_reg   <= pixel.green_in;
            b_reg   <= pixel.blue_in;
            mx_reg  <= mx_next;
            rng_reg <= mx_next - mn_next;
            sec_reg <= sec_next;
        end
    end

    // Stage B: dividend and divisor for hue and saturation, and the finished
    // value. Each dividend is 2*num + den over a divisor of 2*den, so the floor
    // quotient comes out rounded half up.
    // Hue sums are taken modulo 2**18; the true value always fits.
    logic [17:0] r18, g18, b18, rng18, hue_n, hue_num;
    logic [8:0]  hue_den;
    logic [15:0] sat_num;
    logic [8:0]  sat_den;
    logic [14:0] val_y;
    logic [29:0] val_prod;
    logic [6:0]  val_next;

    assign r18   = 18'(r_reg);
    assign g18   = 18'(g_reg);
    assign b18   = 18'(b_reg);
    assign rng18 = 18'(rng_reg);

    always_comb
    begin
        unique case (sec_reg)
            rhsv_pkg::SEC_RED:
            begin
                hue_n = rhsv_pkg::HUE_K60 * g18 - rhsv_pkg::HUE_K60 * b18;
                if (g_reg < b_reg)
                    hue_n = hue_n + rhsv_pkg::HUE_K360 * rng18;
            end
            rhsv_pkg::SEC_GREEN:
                hue_n = rhsv_pkg::HUE_K120 * rng18 + rhsv_pkg::HUE_K60 * b18
                      - rhsv_pkg::HUE_K60 * r18;
            rhsv_pkg::SEC_BLUE:
                hue_n = rhsv_pkg::HUE_K240 * rng18 + rhsv_pkg::HUE_K60 * r18
                      - rhsv_pkg::HUE_K60 * g18;
            default:
                hue_n = '0;
        endcase

        // Grey pixel: force 0 / 1 so the divider yields zero
        if (rng_reg == '0)
        begin
            hue_num = '0;
            hue_den = 9'd1;
        end
        else
        begin
            hue_num = {hue_n[16:0], 1'b0} + rng18;
            hue_den = {rng_reg, 1'b0};
        end

        // Black pixel: saturation is zero
        if (mx_reg == '0)
        begin
            sat_num = '0;
            sat_den = 9'd1;
        end
        else
        begin
            sat_num = rhsv_pkg::PCT_K200 * 16'(rng_reg) + 16'(mx_reg);
            sat_den = {mx_reg, 1'b0};
        end

        // Value: round half up of 100*mx/255, by multiplying with the
        // reciprocal of 255; the constants reduce to shifts and adds
        val_y    = rhsv_pkg::VAL_K100 * 15'(mx_reg) + rhsv_pkg::VAL_HALF;
        val_prod = 30'(val_y) * rhsv_pkg::VAL_RECIP;
        val_next = val_prod[rhsv_pkg::VAL_SHIFT +: 7];
    end

    logic [17:0] hue_num_reg;
    logic [8:0]  hue_den_reg, sat_den_reg;
    logic [15:0] sat_num_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            hue_num_reg <= hue_num;
            hue_den_reg <= hue_den;
            sat_num_reg <= sat_num;
            sat_den_reg <= sat_den;
        end
    end

    // Carry the value alongside the divider stages
    logic [6:0] val_pipe_reg [QW+1];

    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            val_pipe_reg[0] <= val_next;
        end
        for (int k = 1; k <= QW; k++)
        begin
            if (adv[k+1])
            begin
                val_pipe_reg[k] <= val_pipe_reg[k-1];
            end
        end
    end

    // Dividers: nine stages each, advancing in step
    logic [QW-1:0] hue_q, sat_q;

    rhsv_div #(.NW(rhsv_pkg::HUE_NW), .DW(rhsv_pkg::DEN_W), .QW(QW)) u_hue_div (
        .clk (clk),
        .adv (adv[NS-1:2]),
        .num (hue_num_reg),
        .den (hue_den_reg),
        .quo (hue_q)
    );

    rhsv_div #(.NW(rhsv_pkg::PCT_NW), .DW(rhsv_pkg::DEN_W), .QW(QW)) u_sat_div (
        .clk (clk),
        .adv (adv[NS-1:2]),
        .num (sat_num_reg),
        .den (sat_den_reg),
        .quo (sat_q)
    );

    // Drop the unused upper quotient bits of the saturation
    assign hsv.hue_deg = hue_q;
    assign hsv.sat_pct = sat_q[6:0];
    assign hsv.val_pct = val_pipe_reg[QW];

endmodule

// ----- src/rhsv_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the caller guarantees quotient < 2**QW and den != 0.
module rhsv_div #(
    parameter int NW = 18,
    parameter int DW = 9,
    parameter int QW = 9
) (
    input  logic          clk,
    input  logic [QW-1:0] adv,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic [QW-1:0] quo
);

    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] rem_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [QW-1:0] q_reg   [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        localparam int B = QW - 1 - k;

        logic [NW-1:0] rem_cur;
        logic [DW-1:0] den_cur;
        logic [QW-1:0] q_cur;
        logic [CW-1:0] rem_ext;
        logic [CW-1:0] den_sh;
        logic [NW-1:0] rem_next;
        logic [QW-1:0] q_next;

        if (k == 0) begin : g_first
            assign rem_cur = num;
            assign den_cur = den;
            assign q_cur   = '0;
        end
        else begin : g_rest
            assign rem_cur = rem_reg[k-1];
            assign den_cur = den_reg[k-1];
            assign q_cur   = q_reg[k-1];
        end

        assign rem_ext = CW'(rem_cur);
        assign den_sh  = CW'(den_cur) << B;

        always_comb
        begin
            if (rem_ext >= den_sh)
            begin
                rem_next = NW'(rem_ext - den_sh);
                q_next   = q_cur | (QW'(1) << B);
            end
            else
            begin
                rem_next = rem_cur;
                q_next   = q_cur;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k])
            begin
                rem_reg[k] <= rem_next;
                den_reg[k] <= den_cur;
                q_reg[k]   <= q_next;
            end
        end
    end

    assign quo = q_reg[QW-1];

endmodule

// ----- src/rhsv_check.sv -----
// Port-level checker for the RGB to HSV converter, bound to the top level.
// Depends on rhsv_pkg for the payload types.
module rhsv_check (
    input logic             clk,
    input logic             rst_n,
    input logic             pixel_valid,
    input logic             pixel_stall,
    input rhsv_pkg::pixel_t pixel,
    input logic             hsv_valid,
    input logic             hsv_stall,
    input rhsv_pkg::hsv_t   hsv
);

    // No result can leave straight out of reset
    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !hsv_valid)
        else $error("result valid just after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid && hsv_stall |=> hsv_valid && $stable(hsv))
        else $error("stalled result changed");

    // Requests are held back only when the pipeline is full and blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        pixel_stall |-> hsv_valid && hsv_stall)
        else $error("request stalled with room in the pipeline");

    // Result fields stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        hsv_valid |-> hsv.hue_deg <= 9'd360 && hsv.sat_pct <= 7'd100
                      && hsv.val_pct <= 7'd100)
        else $error("result field out of range");

endmodule

bind rgb_to_hsv_converter rhsv_check u_rhsv_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .hsv_valid   (hsv_valid),
    .hsv_stall   (hsv_stall),
    .hsv         (hsv)
);
